@@ design/joystick_deadzone_drive_mixer_defines.svh @@
// assertion macros shared by the joystick mixer rtl
// needs clk and rst_n in the scope where a macro is used
`ifndef JOYSTICK_DEADZONE_DRIVE_MIXER_DEFINES_SVH
`define JOYSTICK_DEADZONE_DRIVE_MIXER_DEFINES_SVH

// same-cycle implication
`define JDM_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("jdm assertion failed");

// next-cycle implication
`define JDM_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("jdm assertion failed");

`endif

@@ design/jdm_pkg.sv @@
// types, constants and helper functions for the joystick mixer
// no dependencies
package jdm_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int DIV_BITS = 24;
    localparam int VEC_XW = 19;
    localparam int ROT_XW = 24;
    localparam int ZW = 18;
    localparam logic [14:0] QUARTER_Q8 = 15'd23040;
    localparam logic [16:0] INV_GAIN_Q16 = 17'd39798;

    typedef enum logic [1:0] {
        REG_DEADZONE = 2'd0,
        REG_SNAP     = 2'd1,
        REG_MODE     = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_SINGLE = 2'd0,
        MODE_DOUBLE = 2'd1,
        MODE_TANK   = 2'd2,
        MODE_NONE   = 2'd3
    } drive_mode_t;

    typedef struct packed {
        logic signed [7:0] lx;
        logic signed [7:0] ly;
        logic signed [7:0] rx;
        logic signed [7:0] ry;
        logic              slow;
        logic              zero;
    } side_t;

    typedef struct packed {
        logic [7:0]          rem;
        logic [DIV_BITS-1:0] num;
        logic [DIV_BITS-1:0] q;
        logic [7:0]          d;
    } div_t;

    typedef struct packed {
        logic        snap;
        logic        vertical;
        logic [15:0] rr;
    } snap_t;

    function automatic logic [13:0] atan_q8(input logic [4:0] idx);
        logic [13:0] a;
        case (idx)
            5'd0:    a = 14'd11520;
            5'd1:    a = 14'd6801;
            5'd2:    a = 14'd3593;
            5'd3:    a = 14'd1824;
            5'd4:    a = 14'd916;
            5'd5:    a = 14'd458;
            5'd6:    a = 14'd229;
            5'd7:    a = 14'd115;
            5'd8:    a = 14'd57;
            5'd9:    a = 14'd29;
            5'd10:   a = 14'd14;
            5'd11:   a = 14'd7;
            5'd12:   a = 14'd4;
            5'd13:   a = 14'd2;
            5'd14:   a = 14'd1;
            default: a = 14'd0;
        endcase
        return a;
    endfunction

    // round half away from zero, q8 to integer
    function automatic logic signed [15:0] round_q8(input logic signed [ROT_XW-1:0] v);
        logic signed [ROT_XW:0] w;
        logic signed [ROT_XW:0] m;
        w = (ROT_XW+1)'(v);
        if (v >= 0)
        begin
            m = (w + (ROT_XW+1)'(128)) >>> 8;
            return m[15:0];
        end
        else
        begin
            m = (-w + (ROT_XW+1)'(128)) >>> 8;
            return -m[15:0];
        end
    endfunction

    // when slow, divide by two toward zero; then clamp to +-127
    function automatic logic signed [7:0] half_sat(input logic signed [17:0] v, input logic slow);
        logic signed [17:0] h;
        h = slow ? ((v + signed'(18'(v[17]))) >>> 1) : v;
        if (h > 18'sd127)
            return 8'sd127;
        else if (h < -18'sd127)
            return -8'sd127;
        else
            return h[7:0];
    endfunction

endpackage

@@ design/jdm_delay.sv @@
// fixed-depth delay line for sideband data
// no dependencies
module jdm_delay #(
    parameter int W = 8,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] line_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        line_reg[0] <= d;
        for (int k = 1; k < DEPTH; k++)
        begin
            line_reg[k] <= line_reg[k-1];
        end
    end

    assign q = line_reg[DEPTH-1];

endmodule

@@ design/jdm_cordic_cell.sv @@
// one registered cordic micro-rotation, vectoring or rotating
// depends on jdm_pkg
module jdm_cordic_cell #(
    parameter int STAGE = 0,
    parameter bit VECTOR = 1'b1,
    parameter int XW = 19,
    parameter int ZW = 18
) (
    input  logic                 clk,
    input  logic signed [XW-1:0] x_in,
    input  logic signed [XW-1:0] y_in,
    input  logic signed [ZW-1:0] z_in,
    output logic signed [XW-1:0] x_out,
    output logic signed [XW-1:0] y_out,
    output logic signed [ZW-1:0] z_out
);

    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [ZW-1:0] ang;
    logic                 cw;
    logic signed [XW-1:0] x_next;
    logic signed [XW-1:0] y_next;
    logic signed [ZW-1:0] z_next;
    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;

    assign xs  = x_in >>> STAGE;
    assign ys  = y_in >>> STAGE;
    assign ang = ZW'(jdm_pkg::atan_q8(5'(STAGE)));
    assign cw  = VECTOR ? (y_in > 0) : (z_in < 0);

    always_comb
    begin
        if (cw)
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ang;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ang;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

@@ design/jdm_div_cell.sv @@
// one registered restoring-division step, one quotient bit
// depends on jdm_pkg
module jdm_div_cell (
    input  logic          clk,
    input  jdm_pkg::div_t din,
    output jdm_pkg::div_t dout
);

    logic [8:0]    t;
    logic          ge;
    logic [8:0]    diff;
    jdm_pkg::div_t step_next;
    jdm_pkg::div_t step_reg;

    assign t    = {din.rem, din.num[jdm_pkg::DIV_BITS-1]};
    assign ge   = t >= {1'b0, din.d};
    assign diff = t - {1'b0, din.d};

    always_comb
    begin
        step_next.rem = ge ? diff[7:0] : t[7:0];
        step_next.num = {din.num[jdm_pkg::DIV_BITS-2:0], 1'b0};
        step_next.q   = {din.q[jdm_pkg::DIV_BITS-2:0], ge};
        step_next.d   = din.d;
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
    end

    assign dout = step_reg;

endmodule

@@ design/joystick_deadzone_drive_mixer.sv @@
// Joystick mixer: takes one sample every clock and returns the motor pair
// on done after the vectoring cordic chain, the 24-step divider chain and
// the rotating cordic chain; busy stays low. The result is shown for one
// cycle only and cannot be held.
// depends on jdm_pkg, jdm_delay, jdm_cordic_cell, jdm_div_cell
`include "joystick_deadzone_drive_mixer_defines.svh"
module joystick_deadzone_drive_mixer #(
    parameter int CORDIC_STAGES = jdm_pkg::CORDIC_STAGES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic signed [7:0] left_x,
    input  logic signed [7:0] left_y,
    input  logic signed [7:0] right_x,
    input  logic signed [7:0] right_y,
    input  logic              slow_button,
    input  logic              wr_en,
    input  logic [1:0]        wr_index,
    input  logic [6:0]        wr_data,
    output logic              done,
    output logic signed [7:0] left_drive,
    output logic signed [7:0] right_drive
);

    localparam int N = CORDIC_STAGES;
    localparam int D = jdm_pkg::DIV_BITS;
    localparam int VXW = jdm_pkg::VEC_XW;
    localparam int RXW = jdm_pkg::ROT_XW;
    localparam int ZW = jdm_pkg::ZW;
    localparam int LAT_E = 2*N + 3 + D;
    localparam int SIDE_W = $bits(jdm_pkg::side_t);
    localparam int SNAP_W = $bits(jdm_pkg::snap_t);

    logic [6:0]           deadzone_reg;
    logic [5:0]           tol_reg;
    jdm_pkg::drive_mode_t mode_reg;
    logic [LAT_E:0]       vld_reg;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg <= 7'd10;
            tol_reg      <= 6'd5;
            mode_reg     <= jdm_pkg::MODE_SINGLE;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                jdm_pkg::REG_DEADZONE: deadzone_reg <= wr_data;
                jdm_pkg::REG_SNAP:     tol_reg <= wr_data[5:0];
                jdm_pkg::REG_MODE:     mode_reg <= jdm_pkg::drive_mode_t'(wr_data[1:0]);
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT_E-1:0], start};
    end

    // input stage
    logic [15:0]     sq_x;
    logic [15:0]     sq_y;
    logic [16:0]     sq_sum;
    logic [13:0]     dz_sq;
    jdm_pkg::side_t  side0_reg;
    logic [8:0]      ax0_reg;
    logic [8:0]      ay0_reg;

    assign sq_x   = 16'(left_x * left_x);
    assign sq_y   = 16'(left_y * left_y);
    assign sq_sum = {1'b0, sq_x} + {1'b0, sq_y};
    assign dz_sq  = deadzone_reg * deadzone_reg;

    always_ff @(posedge clk)
    begin
        side0_reg.lx   <= left_x;
        side0_reg.ly   <= left_y;
        side0_reg.rx   <= right_x;
        side0_reg.ry   <= right_y;
        side0_reg.slow <= slow_button;
        side0_reg.zero <= sq_sum < {3'b0, dz_sq};
        ax0_reg        <= left_x[7] ? -{left_x[7], left_x} : {1'b0, left_x};
        ay0_reg        <= left_y[7] ? -{left_y[7], left_y} : {1'b0, left_y};
    end

    // vectoring chain
    logic signed [VXW-1:0] vx [N+1];
    logic signed [VXW-1:0] vy [N+1];
    logic signed [ZW-1:0]  vz [N+1];

    assign vx[0] = VXW'({ax0_reg, 8'b0});
    assign vy[0] = VXW'({ay0_reg, 8'b0});
    assign vz[0] = '0;

    for (genvar i = 0; i < N; i++)
    begin : g_vec
        jdm_cordic_cell #(.STAGE(i), .VECTOR(1'b1), .XW(VXW), .ZW(ZW)) u_cell (
            .clk   (clk),
            .x_in  (vx[i]),
            .y_in  (vy[i]),
            .z_in  (vz[i]),
            .x_out (vx[i+1]),
            .y_out (vy[i+1]),
            .z_out (vz[i+1])
        );
    end

    // radius and angle clamp
    logic signed [36:0] prod_a;
    logic signed [36:0] rsum_a;
    logic [16:0]        r_a_reg;
    logic [14:0]        zc_a_reg;

    assign prod_a = 37'(vx[N]) * 37'(signed'({1'b0, jdm_pkg::INV_GAIN_Q16}));
    assign rsum_a = prod_a + 37'sd32768;

    always_ff @(posedge clk)
    begin
        r_a_reg <= rsum_a[32:16];
        if (vz[N] < 0)
            zc_a_reg <= '0;
        else if (vz[N] > ZW'(jdm_pkg::QUARTER_Q8))
            zc_a_reg <= jdm_pkg::QUARTER_Q8;
        else
            zc_a_reg <= vz[N][14:0];
    end

    // deadzone subtract, divider setup
    logic signed [17:0] t_b;
    jdm_pkg::div_t      div_b_reg;

    assign t_b = signed'({1'b0, r_a_reg}) - signed'({3'b0, deadzone_reg, 8'b0});

    always_ff @(posedge clk)
    begin
        div_b_reg.rem <= '0;
        div_b_reg.num <= (t_b < 0) ? '0 : {t_b[16:0], 7'b0};
        div_b_reg.q   <= '0;
        div_b_reg.d   <= 8'd128 - {1'b0, deadzone_reg};
    end

    jdm_pkg::div_t dv [D+1];
    assign dv[0] = div_b_reg;

    for (genvar j = 0; j < D; j++)
    begin : g_div
        jdm_div_cell u_cell (
            .clk  (clk),
            .din  (dv[j]),
            .dout (dv[j+1])
        );
    end

    logic [14:0] zc_c;

    jdm_delay #(.W(15), .DEPTH(D+1)) u_phi_dly (
        .clk (clk),
        .d   (zc_a_reg),
        .q   (zc_c)
    );

    // rebuild setup and snap decision
    logic [D+16:0]         prod_c;
    logic [D+16:0]         rsum_c;
    logic [13:0]           tol256;
    logic [14:0]           dist_c;
    logic                  c1;
    logic                  c2;
    logic [D:0]            rr_sum;
    logic signed [RXW-1:0] xr0_reg;
    logic signed [ZW-1:0]  zr0_reg;
    jdm_pkg::snap_t        snap_c_reg;

    assign prod_c = (D+17)'(dv[D].q) * (D+17)'(jdm_pkg::INV_GAIN_Q16);
    assign rsum_c = prod_c + (D+17)'(32768);
    assign tol256 = {tol_reg, 8'b0};
    assign dist_c = jdm_pkg::QUARTER_Q8 - zc_c;
    assign c1     = zc_c < {1'b0, tol256};
    assign c2     = dist_c < {1'b0, tol256};
    assign rr_sum = {1'b0, dv[D].q} + (D+1)'(128);

    always_ff @(posedge clk)
    begin
        xr0_reg             <= signed'(rsum_c[RXW+15:16]);
        zr0_reg             <= ZW'(zc_c);
        snap_c_reg.snap     <= c1 || c2;
        snap_c_reg.vertical <= !c1 || (dist_c <= zc_c);
        snap_c_reg.rr       <= rr_sum[23:8];
    end

    // rotating chain
    logic signed [RXW-1:0] rx_c [N+1];
    logic signed [RXW-1:0] ry_c [N+1];
    logic signed [ZW-1:0]  rz_c [N+1];

    assign rx_c[0] = xr0_reg;
    assign ry_c[0] = '0;
    assign rz_c[0] = zr0_reg;

    for (genvar k = 0; k < N; k++)
    begin : g_rot
        jdm_cordic_cell #(.STAGE(k), .VECTOR(1'b0), .XW(RXW), .ZW(ZW)) u_cell (
            .clk   (clk),
            .x_in  (rx_c[k]),
            .y_in  (ry_c[k]),
            .z_in  (rz_c[k]),
            .x_out (rx_c[k+1]),
            .y_out (ry_c[k+1]),
            .z_out (rz_c[k+1])
        );
    end

    jdm_pkg::snap_t snap_e;
    jdm_pkg::side_t side_e;

    jdm_delay #(.W(SNAP_W), .DEPTH(N)) u_snap_dly (
        .clk (clk),
        .d   (snap_c_reg),
        .q   (snap_e)
    );

    jdm_delay #(.W(SIDE_W), .DEPTH(LAT_E)) u_side_dly (
        .clk (clk),
        .d   (side0_reg),
        .q   (side_e)
    );

    // sign restore, mix, halve, saturate
    logic signed [15:0] px0;
    logic signed [15:0] py0;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [17:0] l_mix;
    logic signed [17:0] r_mix;
    logic               done_reg;
    logic signed [7:0]  left_reg;
    logic signed [7:0]  right_reg;

    always_comb
    begin
        if (snap_e.snap)
        begin
            px0 = snap_e.vertical ? '0 : signed'(snap_e.rr);
            py0 = snap_e.vertical ? signed'(snap_e.rr) : '0;
        end
        else
        begin
            px0 = jdm_pkg::round_q8(rx_c[N]);
            py0 = jdm_pkg::round_q8(ry_c[N]);
        end
        if (side_e.zero)
        begin
            px = '0;
            py = '0;
        end
        else
        begin
            px = side_e.lx[7] ? -px0 : px0;
            py = side_e.ly[7] ? -py0 : py0;
        end
        case (mode_reg)
            jdm_pkg::MODE_SINGLE:
            begin
                l_mix = 18'(py) + 18'(px);
                r_mix = 18'(py) - 18'(px);
            end
            jdm_pkg::MODE_DOUBLE:
            begin
                l_mix = 18'(side_e.ly) + 18'(side_e.rx);
                r_mix = 18'(side_e.ly) - 18'(side_e.rx);
            end
            jdm_pkg::MODE_TANK:
            begin
                l_mix = 18'(side_e.ly);
                r_mix = 18'(side_e.ry);
            end
            default:
            begin
                l_mix = '0;
                r_mix = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_reg[LAT_E];
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= jdm_pkg::half_sat(l_mix, side_e.slow);
        right_reg <= jdm_pkg::half_sat(r_mix, side_e.slow);
    end

    assign done        = done_reg;
    assign left_drive  = left_reg;
    assign right_drive = right_reg;

    `JDM_ASSERT_IMP(a_out_range, done, (left_drive != -8'sd128) && (right_drive != -8'sd128))
    `JDM_ASSERT_NXT(a_mode_none, vld_reg[LAT_E] && (mode_reg == jdm_pkg::MODE_NONE), (left_drive == 8'sd0) && (right_drive == 8'sd0))
    `JDM_ASSERT_NXT(a_deadzone, vld_reg[LAT_E] && (mode_reg == jdm_pkg::MODE_SINGLE) && side_e.zero, (left_drive == 8'sd0) && (right_drive == 8'sd0))

endmodule

@@ verif/joystick_deadzone_drive_mixer_test.sv @@
`timescale 1ns / 100ps
// self-checking testbench for joystick_deadzone_drive_mixer: directed table then random items
// depends on jdm_pkg and the mixer rtl; predicts each untyped motor pair with its own cordic model
module joystick_deadzone_drive_mixer_test;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int STAGES = 16;
    localparam longint QUARTER = 23040;
    localparam longint INV_GAIN = 39798;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LATENCY = 2 * STAGES + 28;
    localparam int RANDOM_ITEMS = 1250;

    localparam longint ATAN_DEG_Q8 [24] = '{11520, 6801, 3593, 1824, 916, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

    typedef struct {
        jdm_pkg::drive_mode_t mode;
        logic [6:0]           dz;
        logic [5:0]           tol;
        logic signed [7:0]    lx, ly, rx, ry;
        logic                 slow;
        bit                   typed;
        logic signed [7:0]    el, er;
    } row_t;

    typedef struct packed {
        logic signed [7:0] l;
        logic signed [7:0] r;
    } drive_pair_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic signed [7:0] left_x, left_y, right_x, right_y;
    logic              slow_button;
    logic              wr_en;
    logic [1:0]        wr_index;
    logic [6:0]        wr_data;
    logic              done;
    logic signed [7:0] left_drive, right_drive;

    logic [6:0]           cur_dz;
    logic [5:0]           cur_tol;
    jdm_pkg::drive_mode_t cur_mode;

    bit                typed_now;
    logic signed [7:0] typed_l, typed_r;

    drive_pair_t pending_drive[$];
    int errors;
    int items_sent;
    int phases;
    int idle_cycles;

    joystick_deadzone_drive_mixer u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .left_x(left_x), .left_y(left_y), .right_x(right_x), .right_y(right_y),
        .slow_button(slow_button), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .done(done), .left_drive(left_drive), .right_drive(right_drive)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint round_half_away(longint v);
        if (v >= 0)
            return (v + 128) >>> 8;
        return -((-v + 128) >>> 8);
    endfunction

    function automatic longint clamp127(longint v);
        if (v > 127)
            return 127;
        if (v < -127)
            return -127;
        return v;
    endfunction

    // radial deadzone, rescale and axis snap of the left stick
    function automatic void shape_left(input longint sx, input longint sy,
                                       output longint ox, output longint oy);
        longint dz, tol, ax, ay, cx, cy, z, rad, rs, qx, qy, px;
        bit vert;
        dz = longint'(cur_dz);
        tol = longint'(cur_tol) * 256;
        ax = sx < 0 ? -sx : sx;
        ay = sy < 0 ? -sy : sy;
        if (sx * sx + sy * sy < dz * dz)
        begin
            ox = 0;
            oy = 0;
            return;
        end
        cx = ax * 256;
        cy = ay * 256;
        z = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            px = cx;
            if (cy > 0)
            begin
                cx += cy >>> i;
                cy -= px >>> i;
                z += ATAN_DEG_Q8[i];
            end
            else
            begin
                cx -= cy >>> i;
                cy += px >>> i;
                z -= ATAN_DEG_Q8[i];
            end
        end
        if (z < 0)
            z = 0;
        if (z > QUARTER)
            z = QUARTER;
        rad = (cx * INV_GAIN + 32768) >>> 16;
        rs = rad - dz * 256;
        if (rs < 0)
            rs = 0;
        rs = (rs * 128) / (128 - dz);
        if (z < tol || QUARTER - z < tol)
        begin
            vert = !(z < tol) || (QUARTER - z <= z);
            qx = vert ? 0 : round_half_away(rs);
            qy = vert ? round_half_away(rs) : 0;
        end
        else
        begin
            cx = (rs * INV_GAIN + 32768) >>> 16;
            cy = 0;
            for (int i = 0; i < STAGES; i++)
            begin
                px = cx;
                if (z >= 0)
                begin
                    cx -= cy >>> i;
                    cy += px >>> i;
                    z -= ATAN_DEG_Q8[i];
                end
                else
                begin
                    cx += cy >>> i;
                    cy -= px >>> i;
                    z += ATAN_DEG_Q8[i];
                end
            end
            qx = round_half_away(cx);
            qy = round_half_away(cy);
        end
        ox = sx < 0 ? -qx : qx;
        oy = sy < 0 ? -qy : qy;
    endfunction

    function automatic drive_pair_t mix_drive(logic signed [7:0] lx, logic signed [7:0] ly,
                                              logic signed [7:0] rx, logic signed [7:0] ry,
                                              logic slow);
        longint x, y, l, r, dv;
        drive_pair_t p;
        x = lx;
        y = ly;
        l = 0;
        r = 0;
        dv = slow ? 2 : 1;
        case (cur_mode)
            jdm_pkg::MODE_SINGLE:
            begin
                shape_left(longint'(lx), longint'(ly), x, y);
                l = y + x;
                r = y - x;
            end
            jdm_pkg::MODE_DOUBLE:
            begin
                l = y + longint'(rx);
                r = y - longint'(rx);
            end
            jdm_pkg::MODE_TANK:
            begin
                l = y;
                r = longint'(ry);
            end
            default: ;
        endcase
        p.l = 8'(clamp127(l / dv));
        p.r = 8'(clamp127(r / dv));
        return p;
    endfunction

    task automatic report_mismatch(string what, logic signed [7:0] got, logic signed [7:0] want);
        errors++;
        if (errors <= 50)
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // accept, predict and check
    always @(posedge clk)
    begin
        drive_pair_t want;
        if (rst_n)
        begin
            idle_cycles++;
            if (start && !busy)
            begin
                idle_cycles = 0;
                if (typed_now)
                begin
                    want.l = typed_l;
                    want.r = typed_r;
                end
                else
                    want = mix_drive(left_x, left_y, right_x, right_y, slow_button);
                pending_drive.push_back(want);
            end
            if (done)
            begin
                idle_cycles = 0;
                if (pending_drive.size() == 0)
                begin
                    errors++;
                    $display("unexpected result at %0t", $realtime);
                end
                else
                begin
                    want = pending_drive.pop_front();
                    if (left_drive !== want.l)
                        report_mismatch("left_drive", left_drive, want.l);
                    if (right_drive !== want.r)
                        report_mismatch("right_drive", right_drive, want.r);
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired at %0t", $realtime);
                $display("joystick_deadzone_drive_mixer test failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [6:0] data);
        @(negedge clk);
        wr_en = 1'b1;
        wr_index = idx;
        wr_data = data;
        @(negedge clk);
        wr_en = 1'b0;
        case (idx)
            jdm_pkg::REG_DEADZONE: cur_dz = data;
            jdm_pkg::REG_SNAP:     cur_tol = data[5:0];
            jdm_pkg::REG_MODE:     cur_mode = jdm_pkg::drive_mode_t'(data[1:0]);
            default: ;
        endcase
    endtask

    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (pending_drive.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_config(logic [6:0] dz, logic [5:0] tol, jdm_pkg::drive_mode_t mode);
        drain();
        write_reg(REG_UNUSED, 7'($urandom));
        write_reg(jdm_pkg::REG_DEADZONE, dz);
        write_reg(jdm_pkg::REG_SNAP, {1'($urandom), tol});
        write_reg(jdm_pkg::REG_MODE, {5'($urandom), mode});
        phases++;
    endtask

    task automatic send_item(logic signed [7:0] lx, logic signed [7:0] ly,
                             logic signed [7:0] rx, logic signed [7:0] ry, logic slow,
                             bit typed, logic signed [7:0] el, logic signed [7:0] er);
        @(negedge clk);
        start = 1'b1;
        left_x = lx;
        left_y = ly;
        right_x = rx;
        right_y = ry;
        slow_button = slow;
        typed_now = typed;
        typed_l = el;
        typed_r = er;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
    endtask

    task automatic random_stick(output logic signed [7:0] v);
        case ($urandom_range(0, 5))
            0:       v = 8'($urandom_range(0, 1) ? 127 : -128);
            1:       v = 8'($urandom_range(0, 24)) - 8'sd12;
            default: v = 8'($urandom);
        endcase
    endtask

    row_t directed[] = '{
        '{jdm_pkg::MODE_SINGLE, 10, 5, 0, 0, 0, 0, 0, 1, 0, 0},
        '{jdm_pkg::MODE_SINGLE, 10, 5, 5, 5, 0, 0, 0, 1, 0, 0},
        '{jdm_pkg::MODE_SINGLE, 10, 5, 127, 0, 0, 0, 0, 0, 0, 0},
        '{jdm_pkg::MODE_SINGLE, 10, 5, 0, -128, 0, 0, 0, 0, 0, 0},
        '{jdm_pkg::MODE_SINGLE, 10, 5, 90, 90, 0, 0, 0, 0, 0, 0},
        '{jdm_pkg::MODE_SINGLE, 10, 5, -128, -128, 5, -3, 1, 0, 0, 0},
        '{jdm_pkg::MODE_SINGLE, 10, 5, 127, 4, 0, 0, 0, 0, 0, 0},
        '{jdm_pkg::MODE_SINGLE, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0},
        '{jdm_pkg::MODE_SINGLE, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0},
        '{jdm_pkg::MODE_SINGLE, 0, 0, -127, 127, 0, 0, 1, 0, 0, 0},
        '{jdm_pkg::MODE_SINGLE, 127, 63, 127, 127, 0, 0, 0, 0, 0, 0},
        '{jdm_pkg::MODE_SINGLE, 127, 63, -128, 100, 0, 0, 0, 0, 0, 0},
        '{jdm_pkg::MODE_SINGLE, 100, 45, -70, 33, 0, 0, 0, 0, 0, 0},
        '{jdm_pkg::MODE_SINGLE, 100, 45, 101, 101, 0, 0, 0, 0, 0, 0},
        '{jdm_pkg::MODE_DOUBLE, 10, 5, 0, 127, -128, 0, 0, 1, -1, 127},
        '{jdm_pkg::MODE_DOUBLE, 10, 5, 0, -128, 127, 0, 0, 1, -1, -127},
        '{jdm_pkg::MODE_DOUBLE, 10, 5, 0, 127, 127, 0, 1, 1, 127, 0},
        '{jdm_pkg::MODE_TANK, 10, 5, 9, -128, 9, 127, 0, 1, -127, 127},
        '{jdm_pkg::MODE_TANK, 10, 5, 9, -128, 9, -127, 1, 1, -64, -63},
        '{jdm_pkg::MODE_NONE, 10, 5, 127, 127, -128, -128, 1, 1, 0, 0},
        '{jdm_pkg::MODE_NONE, 10, 5, -128, 5, 127, 9, 0, 1, 0, 0}
    };

    initial
    begin
        logic signed [7:0] lx, ly, rx, ry;
        logic [6:0] dz;
        logic [5:0] tol;
        jdm_pkg::drive_mode_t mode;
        int burst;
        errors = 0;
        items_sent = 0;
        phases = 0;
        idle_cycles = 0;
        typed_now = 1'b0;
        typed_l = '0;
        typed_r = '0;
        rst_n = 1'b0;
        start = 1'b0;
        left_x = '0;
        left_y = '0;
        right_x = '0;
        right_y = '0;
        slow_button = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        cur_dz = 7'd10;
        cur_tol = 6'd5;
        cur_mode = jdm_pkg::MODE_SINGLE;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // first rows run on reset values
        foreach (directed[i])
        begin
            if (directed[i].mode != cur_mode || directed[i].dz != cur_dz
                || directed[i].tol != cur_tol)
                set_config(directed[i].dz, directed[i].tol, directed[i].mode);
            send_item(directed[i].lx, directed[i].ly, directed[i].rx, directed[i].ry,
                      directed[i].slow, directed[i].typed, directed[i].el, directed[i].er);
        end
        @(negedge clk);
        start = 1'b0;
        typed_now = 1'b0;

        for (int n = 0; n < RANDOM_ITEMS; )
        begin
            if (n % 125 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       dz = 7'd0;
                    1:       dz = 7'd127;
                    default: dz = 7'($urandom_range(0, 100));
                endcase
                tol = $urandom_range(0, 3) == 0 ? 6'd63 : 6'($urandom_range(0, 45));
                mode = $urandom_range(0, 9) < 6 ? jdm_pkg::MODE_SINGLE
                                                : jdm_pkg::drive_mode_t'($urandom_range(0, 3));
                set_config(dz, tol, mode);
            end
            burst = $urandom_range(1, 30);
            for (int b = 0; b < burst && n < RANDOM_ITEMS; b++)
            begin
                random_stick(lx);
                random_stick(ly);
                random_stick(rx);
                random_stick(ry);
                send_item(lx, ly, rx, ry, 1'($urandom), 1'b0, 8'sd0, 8'sd0);
                n++;
                if (n % 125 == 0)
                    break;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                @(negedge clk);
                start = 1'b0;
                repeat ($urandom_range(0, 12)) @(negedge clk);
            end
        end
        drain();
        repeat (LATENCY + 10) @(negedge clk);

        $display("covered %0d items over %0d register settings, all drive modes", items_sent,
                 phases);
        if (errors == 0 && pending_drive.size() == 0)
            $display("joystick_deadzone_drive_mixer test passed");
        else
            $display("joystick_deadzone_drive_mixer test failed");
        $finish;
    end
endmodule
